// ----- design/mcfp_pkg.sv -----
// shared types and constants for the motor command frame parser
package mcfp_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned WordW = 16;

	localparam logic [ByteW-1:0] HEADER_BYTE = 8'h7e;
	localparam logic [ByteW-1:0] TAIL_BYTE   = 8'hee;
	localparam logic [WordW-1:0] MIN_LENGTH  = 16'd7;
	localparam logic [WordW-1:0] DUTY_LIMIT_RESET = 16'd2000;

	// body byte positions, position zero is frame offset three
	localparam logic [WordW-1:0] POS_DIR0    = 16'd0;
	localparam logic [WordW-1:0] POS_DUTY0_H = 16'd1;
	localparam logic [WordW-1:0] POS_DUTY0_L = 16'd2;
	localparam logic [WordW-1:0] POS_DIR1    = 16'd3;
	localparam logic [WordW-1:0] POS_DUTY1_H = 16'd4;
	localparam logic [WordW-1:0] POS_DUTY1_L = 16'd5;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_LEN_HI = 4'b0010,
		PH_LEN_LO = 4'b0100,
		PH_BODY   = 4'b1000
	} phase_t;

	typedef struct packed {
		logic             frame_ok;
		logic [WordW-1:0] compare_one;
		logic [WordW-1:0] compare_two;
		logic [WordW-1:0] compare_three;
		logic [WordW-1:0] compare_four;
	} result_t;

endpackage

// ----- design/motor_command_frame_parser_top.sv -----
// top level of the motor command frame parser: input stage, parser, result buffer
//
// channel   direction  handshake                 payload
// in        input      in_valid / in_ready       rx_byte
// out       output     out_valid / out_ready     frame_ok, compare_one .. compare_four
// cfg       input      cfg_valid / cfg_ready     cfg_data (duty_limit)
//
// one byte per cycle sustained while the input is not stalled; a byte is registered in
// the input stage, and its result is written into the result buffer as it leaves that stage
// a two-entry result buffer (output register plus skid) lets bytes keep flowing
// while a result waits; input stalls only once both entries are full
// reset clears the parser to idle, compares to zero and duty_limit to 2000
// cfg_ready is always high, the register is written the same edge
module motor_command_frame_parser_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [mcfp_pkg::ByteW-1:0]  rx_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        frame_ok,
	output logic [mcfp_pkg::WordW-1:0]  compare_one,
	output logic [mcfp_pkg::WordW-1:0]  compare_two,
	output logic [mcfp_pkg::WordW-1:0]  compare_three,
	output logic [mcfp_pkg::WordW-1:0]  compare_four,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [mcfp_pkg::WordW-1:0]  cfg_data
);
	import mcfp_pkg::*;

	// configuration register
	logic [WordW-1:0] duty_limit_q;

	// input stage
	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             s1_fire;

	// parser result for the byte in the input stage
	logic    emit;
	result_t res;
	logic    push;

	// result buffer
	logic    out_valid_q, skid_valid_q;
	result_t out_q, skid_q;
	logic    pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_limit_q <= DUTY_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			duty_limit_q <= cfg_data;
		end
	end

	// the stage moves on whenever the skid entry is free, so a result always has room
	assign s1_fire  = valid_s1 && !skid_valid_q;
	assign in_ready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	mcfp_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (s1_fire),
		.rx_byte    (byte_s1),
		.duty_limit (duty_limit_q),
		.emit       (emit),
		.res        (res)
	);

	assign push = s1_fire && emit;
	assign pop  = out_valid_q && out_ready;

	// result buffer: skid fills only while the output register is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= push;
				end
			end else if (!out_valid_q) begin
				out_valid_q <= push;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			out_q <= skid_q;
		end else if ((pop || !out_valid_q) && push) begin
			out_q <= res;
		end
		if (push && out_valid_q && !pop) begin
			skid_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign frame_ok      = out_q.frame_ok;
	assign compare_one   = out_q.compare_one;
	assign compare_two   = out_q.compare_two;
	assign compare_three = out_q.compare_three;
	assign compare_four  = out_q.compare_four;

	// skid entry is only used behind a full output register
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid with empty output register");

	// input stalls only with a byte waiting and both result entries full
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && skid_valid_q && out_valid_q))
		else $error("input stalled without a full result buffer");

	// an applied frame drives at most one side of each bridge
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_ok) |->
			((compare_one == '0 || compare_three == '0) &&
			 (compare_two == '0 || compare_four == '0)))
		else $error("both sides of a bridge driven");

	// a buffered result waits while the output is held
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_q)))
		else $error("held result changed");

endmodule

// ----- design/mcfp_parse.sv -----
// frame parser state machine and compare mapping, one byte per enabled cycle
module mcfp_parse (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic [mcfp_pkg::ByteW-1:0]  rx_byte,
	input  logic [mcfp_pkg::WordW-1:0]  duty_limit,
	output logic                        emit,
	output mcfp_pkg::result_t           res
);
	import mcfp_pkg::*;

	phase_t           phase_q, phase_d;
	logic [WordW-1:0] pos_q, pos_d;
	logic [WordW-1:0] len_q, len_d;
	logic [1:0]       dir_q, dir_d;
	logic [WordW-1:0] duty0_q, duty0_d, duty1_q, duty1_d;
	logic [WordW-1:0] cmp_q [4];
	logic [WordW-1:0] cmp_d [4];
	logic             ok;
	logic             apply;
	logic [WordW-1:0] full_len;

	assign full_len = {len_q[WordW-1:ByteW], rx_byte};

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		len_d   = len_q;
		dir_d   = dir_q;
		duty0_d = duty0_q;
		duty1_d = duty1_q;
		emit    = 1'b0;
		ok      = 1'b0;
		apply   = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (rx_byte == HEADER_BYTE) begin
					phase_d = PH_LEN_HI;
					pos_d   = '0;
				end
			end
			PH_LEN_HI: begin
				len_d   = {rx_byte, {ByteW{1'b0}}};
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				len_d = full_len;
				pos_d = '0;
				if (full_len < MIN_LENGTH) begin
					emit    = 1'b1;
					phase_d = PH_IDLE;
				end else begin
					phase_d = PH_BODY;
				end
			end
			PH_BODY: begin
				case (pos_q)
					POS_DIR0:    dir_d[0] = (rx_byte != '0);
					POS_DUTY0_H: duty0_d  = {rx_byte, {ByteW{1'b0}}};
					POS_DUTY0_L: duty0_d  = {duty0_q[WordW-1:ByteW], rx_byte};
					POS_DIR1:    dir_d[1] = (rx_byte != '0);
					POS_DUTY1_H: duty1_d  = {rx_byte, {ByteW{1'b0}}};
					POS_DUTY1_L: duty1_d  = {duty1_q[WordW-1:ByteW], rx_byte};
					default: ;
				endcase
				if (pos_q == len_q - 16'd1) begin
					emit    = 1'b1;
					phase_d = PH_IDLE;
					pos_d   = '0;
					ok      = (rx_byte == TAIL_BYTE) && (duty0_q <= duty_limit)
					          && (duty1_q <= duty_limit);
					apply   = ok;
				end else begin
					pos_d = pos_q + 16'd1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// direction selects which side of each bridge gets the duty
	always_comb begin
		cmp_d = cmp_q;
		if (apply) begin
			cmp_d[0] = dir_q[0] ? duty0_q : '0;
			cmp_d[2] = dir_q[0] ? '0 : duty0_q;
			cmp_d[1] = dir_q[1] ? '0 : duty1_q;
			cmp_d[3] = dir_q[1] ? duty1_q : '0;
		end
	end

	assign res.frame_ok      = ok;
	assign res.compare_one   = cmp_d[0];
	assign res.compare_two   = cmp_d[1];
	assign res.compare_three = cmp_d[2];
	assign res.compare_four  = cmp_d[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			len_q   <= '0;
			dir_q   <= '0;
			duty0_q <= '0;
			duty1_q <= '0;
			cmp_q   <= '{default: '0};
		end else if (en) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			len_q   <= len_d;
			dir_q   <= dir_d;
			duty0_q <= duty0_d;
			duty1_q <= duty1_d;
			cmp_q   <= cmp_d;
		end
	end

endmodule
